// ----- sv/sbpa_pkg.sv -----
package sbpa_pkg;

    localparam int REQ_W       = 14;
    localparam int DIM_W       = 15;
    localparam int SLOT_W      = 4;
    localparam int IDLE_W      = 9;
    localparam int LIMIT_W     = 8;
    localparam int FUNC_W      = 3;
    localparam int STATUS_W    = 2;

    localparam logic [IDLE_W-1:0]  IDLE_MAX    = 9'd511;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd60;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ACQ_ROUND = 3'd0,
        FUNC_ACQ_EXACT = 3'd1,
        FUNC_RELEASE   = 3'd2,
        FUNC_TICK      = 3'd3,
        FUNC_CLEAR     = 3'd4
    } func_e_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_e_t;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic scan;
        logic apply;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_op;
        logic scan_end;
        logic out_free;
    } dp_status_t;

endpackage

// ----- sv/sized_buffer_pool_with_aging.sv -----
// sized buffer pool with idle aging: a table of up to POOL_DEPTH entries, each
// holding a width, a height, busy and live marks and an idle-frame count; sizes
// and idle counts are kept in a small memory, and entries are filled in order at
// the fill mark. func 0 acquires with each size clamped to at least 1 and rounded
// up to a power of two, taking the first free live entry at least that large;
// func 1 acquires an entry of exactly the clamped size; with no fit a new entry
// is appended, or status 1 reports the pool full. func 2 releases a slot (status
// 2 when the slot is at or beyond the fill mark), func 3 ages free live entries
// and retires those whose idle count passes idle_frame_limit, func 4 empties the
// pool. Retired slots are not reused until a clear. Every request gives exactly
// one response. Timing: acquire and frame tick walk the entries one per cycle
// through the memory read port up to the fill mark, and an acquire stops early
// when it hits; release, clear and the unused codes skip the walk. A finished
// response sits in an output register, so the next request is taken while it
// waits. idle_frame_limit is written through the cfg port, which is always
// ready; write it only while no request is in flight.
module sized_buffer_pool_with_aging #(
    parameter int POOL_DEPTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sbpa_pkg::LIMIT_W-1:0]  idle_frame_limit,
    // request channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [sbpa_pkg::FUNC_W-1:0]   func,
    input  logic [sbpa_pkg::REQ_W-1:0]    req_width,
    input  logic [sbpa_pkg::REQ_W-1:0]    req_height,
    input  logic [sbpa_pkg::SLOT_W-1:0]   slot,
    // response channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [sbpa_pkg::STATUS_W-1:0] status,
    output logic [sbpa_pkg::SLOT_W-1:0]   granted_slot,
    output logic                          reused,
    output logic [sbpa_pkg::DIM_W-1:0]    granted_width,
    output logic [sbpa_pkg::DIM_W-1:0]    granted_height
);
    import sbpa_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t dp_stat;

    // the user must change the limit register only between requests; the block does not enforce it
    assign cfg_ready = 1'b1;

    // sequencer: idle, entry walk, commit and respond
    sbpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .dp_stat  (dp_stat),
        .cmd      (cmd)
    );

    // pool table, entry walk and response register
    sbpa_datapath #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .dp_stat          (dp_stat),
        .cfg_valid        (cfg_valid),
        .idle_frame_limit (idle_frame_limit),
        .func             (func),
        .req_width        (req_width),
        .req_height       (req_height),
        .slot             (slot),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .status           (status),
        .granted_slot     (granted_slot),
        .reused           (reused),
        .granted_width    (granted_width),
        .granted_height   (granted_height)
    );

endmodule

// ----- sv/sbpa_ctrl.sv -----
module sbpa_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  sbpa_pkg::dp_status_t dp_stat,
    output sbpa_pkg::ctrl_cmd_t  cmd
);
    import sbpa_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY
    } state_t;

    state_t state_reg;
    logic   in_stall_reg;

    always_comb
    begin
        cmd.start = (state_reg == S_IDLE) && in_valid;
        cmd.scan  = (state_reg == S_SCAN);
        cmd.apply = (state_reg == S_APPLY) && dp_stat.out_free;
    end

    assign in_stall = in_stall_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            in_stall_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg    <= dp_stat.scan_op ? S_SCAN : S_APPLY;
                        in_stall_reg <= 1'b1;
                    end
                end
                S_SCAN:
                begin
                    if (dp_stat.scan_end)
                    begin
                        state_reg <= S_APPLY;
                    end
                end
                S_APPLY:
                begin
                    if (dp_stat.out_free)
                    begin
                        state_reg    <= S_IDLE;
                        in_stall_reg <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg    <= S_IDLE;
                    in_stall_reg <= 1'b0;
                end
            endcase
        end
    end

endmodule

// ----- sv/sbpa_datapath.sv -----
module sbpa_datapath #(
    parameter int POOL_DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  sbpa_pkg::ctrl_cmd_t                   cmd,
    output sbpa_pkg::dp_status_t                  dp_stat,
    input  logic                                  cfg_valid,
    input  logic [sbpa_pkg::LIMIT_W-1:0]          idle_frame_limit,
    input  logic [sbpa_pkg::FUNC_W-1:0]           func,
    input  logic [sbpa_pkg::REQ_W-1:0]            req_width,
    input  logic [sbpa_pkg::REQ_W-1:0]            req_height,
    input  logic [sbpa_pkg::SLOT_W-1:0]           slot,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [sbpa_pkg::STATUS_W-1:0]         status,
    output logic [sbpa_pkg::SLOT_W-1:0]           granted_slot,
    output logic                                  reused,
    output logic [sbpa_pkg::DIM_W-1:0]            granted_width,
    output logic [sbpa_pkg::DIM_W-1:0]            granted_height
);
    import sbpa_pkg::*;

    localparam int IDX_W  = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int FILL_W = $clog2(POOL_DEPTH + 1);
    localparam int CMP_W  = (FILL_W > SLOT_W) ? FILL_W : SLOT_W;

    // smallest power of two not below v (v >= 1)
    function automatic logic [DIM_W-1:0] round_pow2(input logic [REQ_W-1:0] v);
        logic [DIM_W-1:0] a;
        a = DIM_W'(v) - DIM_W'(1);
        a = a | (a >> 1);
        a = a | (a >> 2);
        a = a | (a >> 4);
        a = a | (a >> 8);
        return a + DIM_W'(1);
    endfunction

    // entry sizes and idle counts
    logic [2*DIM_W-1:0] dims_mem [POOL_DEPTH];
    logic [IDLE_W-1:0]  idle_mem [POOL_DEPTH];

    logic [2*DIM_W-1:0]    dims_rd_reg;
    logic [IDLE_W-1:0]     idle_rd_reg;

    logic [FUNC_W-1:0]     func_reg;
    logic [DIM_W-1:0]      tw_reg;
    logic [DIM_W-1:0]      th_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic [LIMIT_W-1:0]    limit_reg;

    logic [FILL_W-1:0]     fill_reg;
    logic [FILL_W-1:0]     fill_next;
    logic [POOL_DEPTH-1:0] busy_reg;
    logic [POOL_DEPTH-1:0] busy_next;
    logic [POOL_DEPTH-1:0] live_reg;
    logic [POOL_DEPTH-1:0] live_next;

    logic [FILL_W-1:0]     issue_reg;
    logic                  eval_valid_reg;
    logic [IDX_W-1:0]      eval_idx_reg;
    logic                  hit_reg;
    logic [IDX_W-1:0]      hit_idx_reg;
    logic [DIM_W-1:0]      hit_w_reg;
    logic [DIM_W-1:0]      hit_h_reg;

    logic                  out_valid_reg;
    status_e_t             out_status_reg;
    logic [SLOT_W-1:0]     out_slot_reg;
    logic                  out_reused_reg;
    logic [DIM_W-1:0]      out_w_reg;
    logic [DIM_W-1:0]      out_h_reg;

    logic [REQ_W-1:0]      w_clamp;
    logic [REQ_W-1:0]      h_clamp;
    logic                  issue_now;
    logic [IDX_W-1:0]      rd_idx;
    logic                  acq_op;
    logic                  exact_op;
    logic [DIM_W-1:0]      rd_w;
    logic [DIM_W-1:0]      rd_h;
    logic                  cand;
    logic                  fits;
    logic                  hit_now;
    logic [IDLE_W-1:0]     idle_inc;
    logic                  slot_ok;
    logic [IDX_W-1:0]      slot_idx;
    logic [IDX_W-1:0]      fill_idx;
    logic                  room;

    logic                  idle_we;
    logic [IDX_W-1:0]      idle_wa;
    logic [IDLE_W-1:0]     idle_wd;
    logic                  dims_we;

    status_e_t             res_status;
    logic [SLOT_W-1:0]     res_slot;
    logic                  res_reused;
    logic [DIM_W-1:0]      res_w;
    logic [DIM_W-1:0]      res_h;

    assign w_clamp = (req_width  == '0) ? REQ_W'(1) : req_width;
    assign h_clamp = (req_height == '0) ? REQ_W'(1) : req_height;

    assign issue_now = cmd.scan && (issue_reg < fill_reg);
    assign rd_idx    = issue_reg[IDX_W-1:0];

    assign acq_op   = (func_reg == FUNC_ACQ_ROUND) || (func_reg == FUNC_ACQ_EXACT);
    assign exact_op = (func_reg == FUNC_ACQ_EXACT);

    assign rd_w = dims_rd_reg[DIM_W-1:0];
    assign rd_h = dims_rd_reg[2*DIM_W-1:DIM_W];

    assign cand = eval_valid_reg && live_reg[eval_idx_reg] && !busy_reg[eval_idx_reg];
    assign fits = exact_op ? ((rd_w == tw_reg) && (rd_h == th_reg))
                           : ((rd_w >= tw_reg) && (rd_h >= th_reg));
    assign hit_now = cmd.scan && acq_op && cand && fits;

    assign idle_inc = (idle_rd_reg == IDLE_MAX) ? IDLE_MAX : idle_rd_reg + IDLE_W'(1);

    assign slot_ok  = CMP_W'(slot_reg) < CMP_W'(fill_reg);
    assign slot_idx = IDX_W'(slot_reg);
    assign fill_idx = fill_reg[IDX_W-1:0];
    assign room     = fill_reg < FILL_W'(POOL_DEPTH);

    always_comb
    begin
        dp_stat.scan_op  = (func == FUNC_ACQ_ROUND) || (func == FUNC_ACQ_EXACT)
                           || (func == FUNC_TICK);
        dp_stat.scan_end = hit_now || (!eval_valid_reg && !(issue_reg < fill_reg));
        dp_stat.out_free = !out_valid_reg || !out_stall;
    end

    // next state of the pool marks, memory writes and the result
    always_comb
    begin
        busy_next  = busy_reg;
        live_next  = live_reg;
        fill_next  = fill_reg;
        idle_we    = 1'b0;
        idle_wa    = eval_idx_reg;
        idle_wd    = idle_inc;
        dims_we    = 1'b0;
        res_status = ST_OK;
        res_slot   = '0;
        res_reused = 1'b0;
        res_w      = '0;
        res_h      = '0;

        // frame tick ages one entry per cycle while scanning
        if (cmd.scan && (func_reg == FUNC_TICK) && cand)
        begin
            idle_we = 1'b1;
            if (idle_inc > IDLE_W'(limit_reg))
            begin
                live_next[eval_idx_reg] = 1'b0;
            end
        end

        if (cmd.apply)
        begin
            unique case (func_reg)
                FUNC_ACQ_ROUND, FUNC_ACQ_EXACT:
                begin
                    if (hit_reg)
                    begin
                        busy_next[hit_idx_reg] = 1'b1;
                        idle_we    = 1'b1;
                        idle_wa    = hit_idx_reg;
                        idle_wd    = '0;
                        res_slot   = SLOT_W'(hit_idx_reg);
                        res_reused = 1'b1;
                        res_w      = hit_w_reg;
                        res_h      = hit_h_reg;
                    end
                    else if (room)
                    begin
                        busy_next[fill_idx] = 1'b1;
                        live_next[fill_idx] = 1'b1;
                        fill_next  = fill_reg + FILL_W'(1);
                        dims_we    = 1'b1;
                        idle_we    = 1'b1;
                        idle_wa    = fill_idx;
                        idle_wd    = '0;
                        res_slot   = SLOT_W'(fill_idx);
                        res_w      = tw_reg;
                        res_h      = th_reg;
                    end
                    else
                    begin
                        res_status = ST_FULL;
                    end
                end
                FUNC_RELEASE:
                begin
                    if (!slot_ok)
                    begin
                        res_status = ST_RANGE;
                    end
                    else if (busy_reg[slot_idx])
                    begin
                        busy_next[slot_idx] = 1'b0;
                        idle_we = 1'b1;
                        idle_wa = slot_idx;
                        idle_wd = '0;
                    end
                end
                FUNC_CLEAR:
                begin
                    busy_next = '0;
                    live_next = '0;
                    fill_next = '0;
                end
                default:
                begin
                    res_status = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue_now)
        begin
            dims_rd_reg <= dims_mem[rd_idx];
        end
        if (dims_we)
        begin
            dims_mem[fill_idx] <= {th_reg, tw_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue_now)
        begin
            idle_rd_reg <= idle_mem[rd_idx];
        end
        if (idle_we)
        begin
            idle_mem[idle_wa] <= idle_wd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg      <= LIMIT_RESET;
            fill_reg       <= '0;
            busy_reg       <= '0;
            live_reg       <= '0;
            issue_reg      <= '0;
            eval_valid_reg <= 1'b0;
            hit_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                limit_reg <= idle_frame_limit;
            end
            fill_reg <= fill_next;
            busy_reg <= busy_next;
            live_reg <= live_next;

            if (cmd.start)
            begin
                issue_reg      <= '0;
                eval_valid_reg <= 1'b0;
                hit_reg        <= 1'b0;
            end
            else if (cmd.scan)
            begin
                if (issue_now)
                begin
                    issue_reg <= issue_reg + FILL_W'(1);
                end
                eval_valid_reg <= issue_now;
                if (hit_now)
                begin
                    hit_reg <= 1'b1;
                end
            end

            if (cmd.apply)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            func_reg <= func;
            slot_reg <= slot;
            tw_reg   <= (func == FUNC_ACQ_EXACT) ? DIM_W'(w_clamp) : round_pow2(w_clamp);
            th_reg   <= (func == FUNC_ACQ_EXACT) ? DIM_W'(h_clamp) : round_pow2(h_clamp);
        end
        if (cmd.scan)
        begin
            eval_idx_reg <= rd_idx;
        end
        if (hit_now)
        begin
            hit_idx_reg <= eval_idx_reg;
            hit_w_reg   <= rd_w;
            hit_h_reg   <= rd_h;
        end
        if (cmd.apply)
        begin
            out_status_reg <= res_status;
            out_slot_reg   <= res_slot;
            out_reused_reg <= res_reused;
            out_w_reg      <= res_w;
            out_h_reg      <= res_h;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign granted_slot   = out_slot_reg;
    assign reused         = out_reused_reg;
    assign granted_width  = out_w_reg;
    assign granted_height = out_h_reg;

endmodule

// ----- dv/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sbpa_pkg::*;

    localparam int POOL_DEPTH   = 16;
    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 1000000;
    // settle time after the last response: a full scan plus margin
    localparam int DRAIN_CYCLES = POOL_DEPTH + 24;
    localparam int PHASE_ITEMS  = 340;
    localparam int NUM_PHASES   = 4;
    localparam int MAX_REPORTS  = 40;

    // func codes the block must treat as no-ops
    localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;
    localparam logic [REQ_W-1:0]  REQ_MAX       = '1;

    // idling per phase: sender idle and receiver stall, in percent
    localparam int                 SEND_IDLE   [NUM_PHASES] = '{0, 85, 0, 12};
    localparam int                 RECV_STALL  [NUM_PHASES] = '{0, 0, 85, 12};
    localparam logic [LIMIT_W-1:0] PHASE_LIMIT [NUM_PHASES] = '{8'd2, 8'd0, 8'd255, 8'd5};

    typedef struct packed {
        logic [FUNC_W-1:0] fn;
        logic [REQ_W-1:0]  w;
        logic [REQ_W-1:0]  h;
        logic [SLOT_W-1:0] sl;
    } pool_req_t;

    typedef struct packed {
        status_e_t         st;
        logic [SLOT_W-1:0] gslot;
        logic              reuse;
        logic [DIM_W-1:0]  gw;
        logic [DIM_W-1:0]  gh;
    } pool_resp_t;

    typedef enum logic {
        ROW_REQ,
        ROW_CFG
    } row_kind_e;

    // one line of the directed table; a config row carries the limit in rq.w
    typedef struct packed {
        row_kind_e  kind;
        pool_req_t  rq;
        logic [3:0] reps;
        logic       typed;
        pool_resp_t resp;
    } dir_row_t;

    localparam pool_resp_t R_OK    = '{ST_OK, 0, 0, 0, 0};
    localparam pool_resp_t R_RANGE = '{ST_RANGE, 0, 0, 0, 0};
    localparam pool_resp_t R_FULL  = '{ST_FULL, 0, 0, 0, 0};

    localparam int DIR_ROWS = 26;
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        // empty pool: release out of range, tick does nothing
        '{ROW_REQ, '{FUNC_RELEASE, 0, 0, 0}, 1, 1, R_RANGE},
        '{ROW_REQ, '{FUNC_TICK, 0, 0, 0}, 1, 1, R_OK},
        // zero sizes clamp to 1, max sizes round to 16384, exact keeps 16383
        '{ROW_REQ, '{FUNC_ACQ_ROUND, 0, 0, 0}, 1, 1, '{ST_OK, 0, 0, 1, 1}},
        '{ROW_REQ, '{FUNC_ACQ_ROUND, REQ_MAX, REQ_MAX, 0}, 1, 1,
          '{ST_OK, 1, 0, 16384, 16384}},
        '{ROW_REQ, '{FUNC_ACQ_EXACT, REQ_MAX, 0, 0}, 1, 1, '{ST_OK, 2, 0, 16383, 1}},
        // rounded acquire reuses a larger free entry
        '{ROW_REQ, '{FUNC_RELEASE, 0, 0, 1}, 1, 1, R_OK},
        '{ROW_REQ, '{FUNC_ACQ_ROUND, 5, 3, 0}, 1, 1, '{ST_OK, 1, 1, 16384, 16384}},
        // second release of a free entry is harmless
        '{ROW_REQ, '{FUNC_RELEASE, 0, 0, 1}, 1, 1, R_OK},
        '{ROW_REQ, '{FUNC_RELEASE, 0, 0, 1}, 1, 1, R_OK},
        // exact acquire skips the larger free entry, then reuses its own
        '{ROW_REQ, '{FUNC_ACQ_EXACT, REQ_MAX, REQ_MAX, 0}, 1, 1,
          '{ST_OK, 3, 0, 16383, 16383}},
        '{ROW_REQ, '{FUNC_RELEASE, 0, 0, 3}, 1, 1, R_OK},
        '{ROW_REQ, '{FUNC_ACQ_EXACT, REQ_MAX, REQ_MAX, 0}, 1, 1,
          '{ST_OK, 3, 1, 16383, 16383}},
        '{ROW_REQ, '{FUNC_RELEASE, 0, 0, 15}, 1, 1, R_RANGE},
        '{ROW_REQ, '{FUNC_SPARE_LO, REQ_MAX, REQ_MAX, 15}, 1, 1, R_OK},
        '{ROW_REQ, '{FUNC_SPARE_HI, 0, 0, 0}, 1, 1, R_OK},
        // limit 0: one tick retires every free entry
        '{ROW_CFG, '{FUNC_TICK, 0, 0, 0}, 1, 0, R_OK},
        '{ROW_REQ, '{FUNC_RELEASE, 0, 0, 0}, 1, 1, R_OK},
        '{ROW_REQ, '{FUNC_TICK, 0, 0, 0}, 1, 1, R_OK},
        // retired slots stay dead, so this appends
        '{ROW_REQ, '{FUNC_ACQ_ROUND, 1, 1, 0}, 1, 1, '{ST_OK, 4, 0, 1, 1}},
        // fill the rest of the pool, then overflow
        '{ROW_REQ, '{FUNC_ACQ_ROUND, 8191, 2, 0}, 11, 0, R_OK},
        '{ROW_REQ, '{FUNC_ACQ_EXACT, 7, 9, 0}, 1, 1, R_FULL},
        '{ROW_REQ, '{FUNC_RELEASE, 0, 0, 15}, 1, 1, R_OK},
        '{ROW_REQ, '{FUNC_ACQ_ROUND, 1, 1, 0}, 1, 1, '{ST_OK, 15, 1, 8192, 2}},
        '{ROW_REQ, '{FUNC_CLEAR, 0, 0, 0}, 1, 1, R_OK},
        '{ROW_REQ, '{FUNC_RELEASE, 0, 0, 0}, 1, 1, R_RANGE},
        '{ROW_CFG, '{FUNC_TICK, 255, 0, 0}, 1, 0, R_OK}
    };

    // dut ports, all inputs known from time zero
    logic                clk            = 1'b0;
    logic                rst_n          = 1'b0;
    logic                cfg_valid      = 1'b0;
    logic                cfg_ready;
    logic [LIMIT_W-1:0]  cfg_limit      = LIMIT_RESET;
    logic                in_valid       = 1'b0;
    logic                in_stall;
    logic [FUNC_W-1:0]   func           = FUNC_TICK;
    logic [REQ_W-1:0]    req_width      = '0;
    logic [REQ_W-1:0]    req_height     = '0;
    logic [SLOT_W-1:0]   slot           = '0;
    logic                out_valid;
    logic                out_stall      = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   granted_slot;
    logic                reused;
    logic [DIM_W-1:0]    granted_width;
    logic [DIM_W-1:0]    granted_height;

    // a typed-in response travels with its request
    logic       req_typed      = 1'b0;
    pool_resp_t req_typed_resp = '0;

    int send_idle_pct = 0;
    int stall_pct     = 0;

    // shadow copy of the pool
    logic [DIM_W-1:0]   pool_w    [POOL_DEPTH];
    logic [DIM_W-1:0]   pool_h    [POOL_DEPTH];
    logic               pool_busy [POOL_DEPTH];
    logic               pool_live [POOL_DEPTH];
    logic [IDLE_W-1:0]  pool_idle [POOL_DEPTH];
    int                 pool_fill   = 0;
    logic [LIMIT_W-1:0] model_limit = LIMIT_RESET;

    pool_resp_t pending_grants[$];

    int error_count    = 0;
    int accepted_count = 0;
    int checked_count  = 0;
    int full_count     = 0;
    int reuse_count    = 0;
    int range_count    = 0;
    int retired_count  = 0;
    int cycle_count    = 0;

    sized_buffer_pool_with_aging #(
        .POOL_DEPTH(POOL_DEPTH)
    ) i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .idle_frame_limit(cfg_limit),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .func            (func),
        .req_width       (req_width),
        .req_height      (req_height),
        .slot            (slot),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .granted_slot    (granted_slot),
        .reused          (reused),
        .granted_width   (granted_width),
        .granted_height  (granted_height)
    );

    always #HALF_PERIOD clk = ~clk;

    // smallest power of two not below v
    function automatic int pow2_ceil(input int v);
        int p;
        p = 1;
        while (p < v)
            p = p << 1;
        return p;
    endfunction

    // applies one request to the shadow pool and returns its response
    function automatic pool_resp_t pool_outcome(input pool_req_t rq);
        pool_resp_t r;
        int         tw;
        int         th;
        int         hit;
        logic       exact;
        r    = '0;
        r.st = ST_OK;
        case (rq.fn)
            FUNC_ACQ_ROUND, FUNC_ACQ_EXACT: begin
                exact = (rq.fn == FUNC_ACQ_EXACT);
                tw    = (rq.w == 0) ? 1 : int'(rq.w);
                th    = (rq.h == 0) ? 1 : int'(rq.h);
                if (!exact) begin
                    tw = pow2_ceil(tw);
                    th = pow2_ceil(th);
                end
                // first fit from the lowest entry upward
                hit = -1;
                for (int i = 0; i < pool_fill; i++) begin
                    if (hit < 0 && pool_live[i] && !pool_busy[i] &&
                        (exact ? (pool_w[i] == tw && pool_h[i] == th)
                               : (pool_w[i] >= tw && pool_h[i] >= th)))
                        hit = i;
                end
                if (hit >= 0) begin
                    pool_busy[hit] = 1'b1;
                    pool_idle[hit] = '0;
                    r.gslot        = SLOT_W'(hit);
                    r.reuse        = 1'b1;
                    r.gw           = pool_w[hit];
                    r.gh           = pool_h[hit];
                end else if (pool_fill >= POOL_DEPTH) begin
                    r.st = ST_FULL;
                end else begin
                    // append at the fill mark
                    pool_w[pool_fill]    = DIM_W'(tw);
                    pool_h[pool_fill]    = DIM_W'(th);
                    pool_busy[pool_fill] = 1'b1;
                    pool_live[pool_fill] = 1'b1;
                    pool_idle[pool_fill] = '0;
                    r.gslot              = SLOT_W'(pool_fill);
                    r.gw                 = DIM_W'(tw);
                    r.gh                 = DIM_W'(th);
                    pool_fill++;
                end
            end
            FUNC_RELEASE: begin
                if (rq.sl >= pool_fill) begin
                    r.st = ST_RANGE;
                end else if (pool_busy[rq.sl]) begin
                    pool_busy[rq.sl] = 1'b0;
                    pool_idle[rq.sl] = '0;
                end
            end
            FUNC_TICK: begin
                // age free live entries, retire those past the limit
                for (int i = 0; i < pool_fill; i++) begin
                    if (pool_live[i] && !pool_busy[i]) begin
                        if (pool_idle[i] != IDLE_MAX)
                            pool_idle[i] = pool_idle[i] + 1'b1;
                        if (pool_idle[i] > model_limit) begin
                            pool_live[i] = 1'b0;
                            retired_count++;
                        end
                    end
                end
            end
            FUNC_CLEAR: begin
                for (int i = 0; i < POOL_DEPTH; i++) begin
                    pool_busy[i] = 1'b0;
                    pool_live[i] = 1'b0;
                end
                pool_fill = 0;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic check_field(input string name, input logic [DIM_W-1:0] want,
                               input logic [DIM_W-1:0] got);
        if (got !== want) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // tracks accepted requests and config writes, checks every response
    always @(posedge clk) begin : scoreboard
        pool_resp_t want;
        if (!rst_n) begin
            for (int i = 0; i < POOL_DEPTH; i++) begin
                pool_w[i]    = '0;
                pool_h[i]    = '0;
                pool_busy[i] = 1'b0;
                pool_live[i] = 1'b0;
                pool_idle[i] = '0;
            end
            pool_fill   = 0;
            model_limit = LIMIT_RESET;
        end else begin
            if (cfg_valid && cfg_ready)
                model_limit = cfg_limit;
            if (in_valid && !in_stall) begin
                // the shadow pool advances even when the response is typed in
                want = pool_outcome('{func, req_width, req_height, slot});
                if (req_typed)
                    want = req_typed_resp;
                pending_grants.insert(pending_grants.size(), want);
                accepted_count++;
            end
            if (out_valid && !out_stall) begin
                if (pending_grants.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: response with no request outstanding, expected none, got status %0d",
                                 $time, status);
                end else begin
                    want = pending_grants.pop_front();
                    check_field("status", DIM_W'(want.st), DIM_W'(status));
                    check_field("granted_slot", DIM_W'(want.gslot), DIM_W'(granted_slot));
                    check_field("reused", DIM_W'(want.reuse), DIM_W'(reused));
                    check_field("granted_width", want.gw, granted_width);
                    check_field("granted_height", want.gh, granted_height);
                    checked_count++;
                    if (want.st == ST_FULL)
                        full_count++;
                    if (want.st == ST_RANGE)
                        range_count++;
                    if (want.reuse)
                        reuse_count++;
                end
            end
        end
    end

    // receiver back-pressure
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // one request: optional idle gap, then hold until accepted
    task automatic send_request(input pool_req_t rq, input logic typed,
                                input pool_resp_t typed_resp);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        func           <= rq.fn;
        req_width      <= rq.w;
        req_height     <= rq.h;
        slot           <= rq.sl;
        req_typed      <= typed;
        req_typed_resp <= typed_resp;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // sender pauses until every response is back
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_grants.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_limit <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // small sizes dominate so exact hits and reuse are common
    function automatic logic [REQ_W-1:0] pick_dim();
        case ($urandom_range(9))
            0:       return '0;
            1:       return REQ_MAX;
            2:       return REQ_W'($urandom_range(REQ_MAX));
            3:       return REQ_W'(1 << $urandom_range(REQ_W - 1));
            default: return REQ_W'($urandom_range(1, 6));
        endcase
    endfunction

    function automatic pool_req_t random_request();
        pool_req_t rq;
        int        pick;
        pick  = $urandom_range(99);
        rq.w  = pick_dim();
        rq.h  = pick_dim();
        // releases mostly aim inside the fill mark
        if (pool_fill > 0 && $urandom_range(3) != 0)
            rq.sl = SLOT_W'($urandom_range(pool_fill - 1));
        else
            rq.sl = SLOT_W'($urandom_range(POOL_DEPTH - 1));
        if (pick < 30)
            rq.fn = FUNC_ACQ_ROUND;
        else if (pick < 48)
            rq.fn = FUNC_ACQ_EXACT;
        else if (pick < 78)
            rq.fn = FUNC_RELEASE;
        else if (pick < 93)
            rq.fn = FUNC_TICK;
        else if (pick < 95)
            rq.fn = FUNC_CLEAR;
        else if (pick < 98)
            rq.fn = FUNC_W'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
        else
            rq.fn = FUNC_RELEASE;
        return rq;
    endfunction

    // run limit
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin : stimulus
        pool_resp_t no_resp;
        no_resp = '0;
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, no idling
        for (int r = 0; r < DIR_ROWS; r++) begin
            if (DIR_TABLE[r].kind == ROW_CFG) begin
                wait_drained();
                write_limit(DIR_TABLE[r].rq.w[LIMIT_W-1:0]);
            end else begin
                repeat (DIR_TABLE[r].reps)
                    send_request(DIR_TABLE[r].rq, DIR_TABLE[r].typed, DIR_TABLE[r].resp);
            end
        end

        // random phases, each with its own idling and aging limit
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            write_limit(PHASE_LIMIT[p]);
            send_idle_pct = SEND_IDLE[p];
            stall_pct     = RECV_STALL[p];
            repeat (PHASE_ITEMS) begin
                if ($urandom_range(39) == 0)
                    wait_drained();
                send_request(random_request(), 1'b0, no_resp);
            end
        end

        wait_drained();
        stall_pct = 0;
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("%0d requests over %0d idling phases, %0d responses checked, %0d errors",
                 accepted_count, NUM_PHASES, checked_count, error_count);
        $display("pool full %0d, reuses %0d, range errors %0d, entries retired %0d",
                 full_count, reuse_count, range_count, retired_count);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
sv/sbpa_pkg.sv
sv/sbpa_ctrl.sv
sv/sbpa_datapath.sv
sv/sized_buffer_pool_with_aging.sv
dv/tb_top.sv
